// ===== rtl/core/dd_pkg.sv =====
// Shared types and constants for the differential-drive pose-rate block.
// Holds the payload structs, fixed-point widths, CORDIC angle table and register indexes.
// No dependencies.
package dd_pkg;

  // Fixed-point working widths
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STAGES = 18;  // setup, overflow check, 16 x 2 quotient bits
  localparam int XW = 27;   // CORDIC x/y, Q.24 with headroom
  localparam int ZW = 20;   // CORDIC angle, Q.16
  localparam int PW = 34;   // radius * wheel sum/diff
  localparam int MW = 42;   // rounded dividend magnitude
  localparam int RW = 48;   // divider remainder
  localparam int QW = 32;   // quotient bits produced

  localparam logic signed [ZW-1:0] ANG_PI      = 20'sd205887;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [XW-1:0] CORDIC_K    = 27'sd10188013;

  // Register indexes
  localparam logic CFG_RADIUS  = 1'b0;
  localparam logic CFG_SPACING = 1'b1;

  localparam logic [15:0] RADIUS_RST  = 16'd4096;
  localparam logic [15:0] SPACING_RST = 16'd16384;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] left_wheel_rate;
    logic signed [15:0] right_wheel_rate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_rate;
    logic signed [31:0] y_rate;
    logic signed [31:0] heading_rate;
  } out_t;

  // atan(2^-i) in Q.16
  function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      4'd0:    a = 20'sd51472;
      4'd1:    a = 20'sd30386;
      4'd2:    a = 20'sd16055;
      4'd3:    a = 20'sd8150;
      4'd4:    a = 20'sd4091;
      4'd5:    a = 20'sd2047;
      4'd6:    a = 20'sd1024;
      4'd7:    a = 20'sd512;
      4'd8:    a = 20'sd256;
      4'd9:    a = 20'sd128;
      4'd10:   a = 20'sd64;
      4'd11:   a = 20'sd32;
      4'd12:   a = 20'sd16;
      4'd13:   a = 20'sd8;
      4'd14:   a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/diff_drive_pose_rate.sv =====
// Differential-drive pose rate: x/y/heading rates from heading and wheel rates.
// Throughput one transaction per cycle while out_stall_i is low, set by the 16-stage CORDIC
// and the divider pipelines.
// Stalls back up stage by stage, so empty stages still fill while the output waits.
// Async active-low reset clears valid bits and loads radius 1.0 m, spacing 4.0 m.
module diff_drive_pose_rate (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dd_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dd_pkg::out_t  out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);
  import dd_pkg::*;

  // Stage map:
  //  1      angle fold into +-pi/2, wheel sum and difference
  //  2      radius products; CORDIC iteration 0
  //  2..17  CORDIC; 3..20 divider (setup, overflow, 16 x 2 quotient bits)
  //  18     base * cos/sin
  //  19     round, shift to Q16.16, saturate
  //  21     heading-rate sign/saturation, output register
  localparam int NS = 21;

  logic [15:0] radius_q, spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      spacing_q <= SPACING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS:  radius_q  <= cfg_data_i;
        CFG_SPACING: spacing_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- valid chain: a stage loads when it is empty or its successor moves
  logic [NS:1]   v_q;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = !out_stall_i;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[NS];

  // ---- stage 1
  logic signed [ZW-1:0] z8, z1_d, z1_q;
  logic                 neg1_d, neg1_q;
  logic signed [16:0]   sum1_q, diff1_q;

  always_comb begin
    // heading Q3.13 -> Q.16, sign-extended
    z8     = ZW'($signed({in_data_i.heading, 3'b000}));
    z1_d   = z8;
    neg1_d = 1'b0;
    if (z8 > ANG_HALF_PI) begin
      z1_d   = z8 - ANG_PI;
      neg1_d = 1'b1;
    end else if (z8 < -ANG_HALF_PI) begin
      z1_d   = z8 + ANG_PI;
      neg1_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      z1_q    <= z1_d;
      neg1_q  <= neg1_d;
      sum1_q  <= 17'(in_data_i.left_wheel_rate) + 17'(in_data_i.right_wheel_rate);
      diff1_q <= 17'(in_data_i.right_wheel_rate) - 17'(in_data_i.left_wheel_rate);
    end
  end

  // ---- stage 2: radius products
  logic signed [16:0]   radius_s;
  logic signed [PW-1:0] base_q [2:17];
  logic signed [PW-1:0] prod2_q;

  assign radius_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      base_q[2] <= radius_s * sum1_q;
      prod2_q   <= radius_s * diff1_q;
    end
    for (int k = 3; k <= 17; k++) begin
      if (en[k]) base_q[k] <= base_q[k-1];
    end
  end

  // ---- sin/cos
  logic signed [XW-1:0] cos17, sin17;

  dd_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en[17:2]),
    .z_i   (z1_q),
    .neg_i (neg1_q),
    .cos_o (cos17),
    .sin_o (sin17)
  );

  // ---- heading rate divider
  logic [QW-1:0] quot20;
  logic          ovf20, zero20, neg20;

  dd_div u_div (
    .clk_i     (clk_i),
    .en_i      (en[20:3]),
    .prod_i    (prod2_q),
    .spacing_i (spacing_q),
    .quot_o    (quot20),
    .ovf_o     (ovf20),
    .zero_o    (zero20),
    .neg_o     (neg20)
  );

  // ---- stages 18..20: trig products, rounding
  logic signed [PW+XW-1:0] px18_q, py18_q;
  logic signed [31:0]      x19_q, y19_q, x20_q, y20_q;

  function automatic logic signed [31:0] round_sat(input logic signed [PW+XW-1:0] p);
    logic signed [PW+XW:0] r;
    logic signed [PW+XW:0] s;
    r = (PW+XW+1)'(p) + (PW+XW+1)'(64'sd268435456);
    s = r >>> 29;
    if (s > 33'sd2147483647)       return 32'sh7FFFFFFF;
    else if (s < -33'sd2147483648) return 32'sh80000000;
    else                           return s[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[18]) begin
      px18_q <= base_q[17] * cos17;
      py18_q <= base_q[17] * sin17;
    end
    if (en[19]) begin
      x19_q <= round_sat(px18_q);
      y19_q <= round_sat(py18_q);
    end
    if (en[20]) begin
      x20_q <= x19_q;
      y20_q <= y19_q;
    end
  end

  // ---- stage 21: heading-rate sign and saturation, output register
  logic signed [31:0] hr_d;

  always_comb begin
    if (zero20) begin
      hr_d = '0;
    end else if (neg20) begin
      if (ovf20 || quot20 > 32'h80000000) hr_d = 32'sh80000000;
      else                                 hr_d = -$signed(quot20);
    end else begin
      if (ovf20 || quot20 > 32'h7FFFFFFF) hr_d = 32'sh7FFFFFFF;
      else                                 hr_d = $signed(quot20);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[21]) begin
      out_data_o.x_rate       <= x20_q;
      out_data_o.y_rate       <= y20_q;
      out_data_o.heading_rate <= hr_d;
    end
  end

endmodule

// ===== rtl/core/dd_cordic.sv =====
// Pipelined rotation-mode CORDIC, one iteration per stage, sin/cos in Q.24.
// Uses dd_pkg (widths, gain-loaded start vector, atan table).
module dd_cordic (
  input  logic                          clk_i,
  input  logic [dd_pkg::CORDIC_STEPS-1:0] en_i,
  input  logic signed [dd_pkg::ZW-1:0]  z_i,
  input  logic                          neg_i,
  output logic signed [dd_pkg::XW-1:0]  cos_o,
  output logic signed [dd_pkg::XW-1:0]  sin_o
);
  import dd_pkg::*;

  logic signed [XW-1:0] x_q [CORDIC_STEPS];
  logic signed [XW-1:0] y_q [CORDIC_STEPS];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS];
  logic                 neg_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xp, yp, xn, yn;
    logic signed [ZW-1:0] zp, zn;
    logic                 np;

    if (i == 0) begin : g_first
      assign xp = CORDIC_K;
      assign yp = '0;
      assign zp = z_i;
      assign np = neg_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign np = neg_q[i-1];
    end

    always_comb begin
      if (zp >= 0) begin
        xn = xp - (yp >>> i);
        yn = yp + (xp >>> i);
        zn = zp - atan_q16(4'(i));
      end else begin
        xn = xp + (yp >>> i);
        yn = yp - (xp >>> i);
        zn = zp + atan_q16(4'(i));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        // last stage folds in the half-turn sign flip
        if (i == CORDIC_STEPS - 1 && np) begin
          x_q[i] <= -xn;
          y_q[i] <= -yn;
        end else begin
          x_q[i] <= xn;
          y_q[i] <= yn;
        end
        z_q[i]   <= zn;
        neg_q[i] <= np;
      end
    end
  end

  assign cos_o = x_q[CORDIC_STEPS-1];
  assign sin_o = y_q[CORDIC_STEPS-1];

endmodule

// ===== rtl/core/dd_div.sv =====
// Pipelined restoring divider for the heading rate: |num| rounded by spacing.
// Two quotient bits per stage, overflow flagged up front. Uses dd_pkg.
module dd_div (
  input  logic                         clk_i,
  input  logic [dd_pkg::DIV_STAGES-1:0] en_i,
  input  logic signed [dd_pkg::PW-1:0] prod_i,
  input  logic [15:0]                  spacing_i,
  output logic [dd_pkg::QW-1:0]        quot_o,
  output logic                         ovf_o,
  output logic                         zero_o,
  output logic                         neg_o
);
  import dd_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  logic [MW-1:0] m_q;
  logic [RW-1:0] rem_q [DIV_STAGES];
  logic [QW-1:0] quot_q [DIV_STAGES];
  logic          ovf_q [DIV_STAGES];
  logic          zero_q [DIV_STAGES];
  logic          neg_q [DIV_STAGES];

  logic [PW-1:0] mag;
  logic [MW-1:0] m_d;

  // magnitude, times 256, plus half the divisor for round-to-nearest
  always_comb begin
    mag = prod_i[PW-1] ? PW'(-prod_i) : PW'(prod_i);
    m_d = {mag[MW-9:0], 8'b0} + MW'(spacing_i >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      m_q      <= m_d;
      neg_q[0] <= prod_i[PW-1];
    end
    if (en_i[1]) begin
      rem_q[1]  <= RW'(m_q);
      quot_q[1] <= '0;
      ovf_q[1]  <= RW'(m_q) >= {spacing_i, 32'b0};
      zero_q[1] <= (m_q == '0);
      neg_q[1]  <= neg_q[0];
    end
  end

  for (genvar j = 0; j < 16; j++) begin : g_step
    logic [RW-1:0] r;
    logic [RW-1:0] d;
    logic [QW-1:0] q;

    always_comb begin
      r = rem_q[j+1];
      q = quot_q[j+1];
      for (int b = 0; b < 2; b++) begin
        d = RW'(spacing_i) << (31 - 2*j - b);
        if (r >= d) begin
          r = r - d;
          q[31 - 2*j - b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j+2]) begin
        rem_q[j+2]  <= r;
        quot_q[j+2] <= q;
        ovf_q[j+2]  <= ovf_q[j+1];
        zero_q[j+2] <= zero_q[j+1];
        neg_q[j+2]  <= neg_q[j+1];
      end
    end
  end

  assign quot_o = quot_q[LAST];
  assign ovf_o  = ovf_q[LAST];
  assign zero_o = zero_q[LAST];
  assign neg_o  = neg_q[LAST];

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for diff_drive_pose_rate: random and directed wheel transactions.
// A bit-true predictor (CORDIC sin/cos, scaled sums, rounded division) checks each result.
// Depends on dd_pkg and diff_drive_pose_rate.
module testbench;
  import dd_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic cfg_idx;
  logic [15:0] cfg_data;

  diff_drive_pose_rate u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // predictor's copy of the registers
  logic [15:0] radius_q;
  logic [15:0] spacing_q;

  in_t pending_q[$];     // transactions waiting for the driver
  out_t pose_rate_q[$];  // predicted pose rates, oldest first
  int errors;
  int in_gap;
  int out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit: sized for the worst case of ~2000 items with the longest driver and monitor gaps, taken several times over
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // floor shift on 64-bit signed
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic out_t predict_pose_rate(in_t it);
    longint z, x, y, dx, dy, sum, dif, base, num, q, w, m, hr;
    longint atan_tab[16];
    bit flip;
    out_t r;
    atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                 256, 128, 64, 32, 16, 8, 4, 2};
    z = longint'(it.heading) * 8;
    flip = 1'b0;
    x = 10188013;
    y = 0;
    // fold the angle into [-pi/2, pi/2], negate vector afterwards
    if (z > 102944) begin
      z = z - 205887;
      flip = 1'b1;
    end else if (z < -102944) begin
      z = z + 205887;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sum = longint'(it.left_wheel_rate) + longint'(it.right_wheel_rate);
    dif = longint'(it.right_wheel_rate) - longint'(it.left_wheel_rate);
    base = longint'({1'b0, radius_q}) * sum;
    r.x_rate = clamp32(floor_shr(base * x + (64'sd1 << 28), 29));
    r.y_rate = clamp32(floor_shr(base * y + (64'sd1 << 28), 29));
    num = longint'({1'b0, radius_q}) * dif * 256;
    if (spacing_q == 0) begin
      hr = (num > 0) ? 64'sh7fffffffffffffff : ((num < 0) ? 64'sh8000000000000000 : 0);
    end else begin
      // round to nearest, ties away from zero
      w = longint'({1'b0, spacing_q});
      m = (num < 0) ? -num : num;
      q = (m + w / 2) / w;
      hr = (num < 0) ? -q : q;
    end
    r.heading_rate = clamp32(hr);
    return r;
  endfunction

  // driver: random gap before each transaction, payload held while stalled;
  // a zero gap keeps valid high for a back-to-back transaction
  always @(posedge clk or negedge rst_n) begin
    int gap_pick;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else if (in_valid && !in_stall) begin
      pose_rate_q.push_back(predict_pose_rate(in_data));
      void'(pending_q.pop_front());
      gap_pick = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
      if (gap_pick == 0 && pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_q[0];
        in_gap <= 0;
      end else begin
        in_valid <= 1'b0;
        in_gap <= gap_pick;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_q[0];
      end
    end
  end

  // monitor: random stall per result, field-by-field compare
  always @(posedge clk or negedge rst_n) begin
    out_t exp_r;
    int bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
      errors <= 0;
    end else begin
      bad = 0;
      if (out_valid && !out_stall) begin
        if (pose_rate_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          bad = bad + 1;
        end else begin
          exp_r = pose_rate_q.pop_front();
          if (out_data.x_rate !== exp_r.x_rate) begin
            $display("%0t: x_rate expected %0d actual %0d", $time, exp_r.x_rate,
                     out_data.x_rate);
            bad = bad + 1;
          end
          if (out_data.y_rate !== exp_r.y_rate) begin
            $display("%0t: y_rate expected %0d actual %0d", $time, exp_r.y_rate,
                     out_data.y_rate);
            bad = bad + 1;
          end
          if (out_data.heading_rate !== exp_r.heading_rate) begin
            $display("%0t: heading_rate expected %0d actual %0d", $time,
                     exp_r.heading_rate, out_data.heading_rate);
            bad = bad + 1;
          end
        end
        out_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
        out_stall <= 1'b0;
      end else if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
      end
      errors <= errors + bad;
    end
  end

  function automatic in_t rand_wheels();
    in_t t;
    t.heading = 16'($urandom());
    t.left_wheel_rate = 16'($urandom());
    t.right_wheel_rate = 16'($urandom());
    // often keep rates modest so results do not all saturate
    if ($urandom_range(0, 2) == 0) begin
      t.left_wheel_rate = 16'($urandom_range(0, 1023) - 512);
      t.right_wheel_rate = 16'($urandom_range(0, 1023) - 512);
    end
    return t;
  endfunction

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RADIUS) radius_q = val;
    else spacing_q = val;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || pose_rate_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic push_item(input logic [15:0] h, input logic [15:0] l, input logic [15:0] r);
    in_t t;
    t.heading = h;
    t.left_wheel_rate = l;
    t.right_wheel_rate = r;
    pending_q.push_back(t);
  endtask

  initial begin
    logic [15:0] radius_set[6];
    logic [15:0] spacing_set[6];
    radius_set = '{16'd4096, 16'd1, 16'd65535, 16'd0, 16'd1234, 16'd40000};
    spacing_set = '{16'd16384, 16'd65535, 16'd1, 16'd0, 16'd3, 16'd20000};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_RADIUS;
    cfg_data = '0;
    radius_q = RADIUS_RST;
    spacing_q = SPACING_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: heading extremes, fold boundaries, wheel extremes, zero numerator
    push_item(16'h0000, 16'h0100, 16'h0100);
    push_item(16'h7fff, 16'h7fff, 16'h7fff);
    push_item(16'h8000, 16'h8000, 16'h8000);
    push_item(16'h8000, 16'h7fff, 16'h8000);
    push_item(16'h7fff, 16'h8000, 16'h7fff);
    push_item(16'd12868, 16'h0200, 16'hfe00);
    push_item(16'd12869, 16'h0200, 16'h0300);
    push_item(-16'sd12868, 16'h0200, 16'h0300);
    push_item(-16'sd12869, 16'hff00, 16'h0300);
    push_item(16'h0000, 16'h0000, 16'h0000);
    push_item(16'hffff, 16'hffff, 16'h0001);
    push_item(16'd25736, 16'h1000, 16'h1000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_RADIUS, radius_set[ph]);
      write_reg(CFG_SPACING, spacing_set[ph]);
      push_item(16'h7fff, 16'h7fff, 16'h8000);
      push_item(16'h0000, 16'h0005, 16'h0005);
      for (int k = 0; k < 305; k++) pending_q.push_back(rand_wheels());
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
